FILE: rtl/fbba_pkg.sv
// Shared types, codes and defaults of the free block bitmap allocator.
package fbba_pkg;

   localparam int MAX_BLOCKS_DEF = 4096;
   localparam int WORD_BITS_DEF  = 32;

   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 12;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 13;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   localparam logic [FUNC_W-1:0] FUNC_FIND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_MARK = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_WAS_FREE  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_WAS_USED  = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND,
      ST_LOCATE,
      ST_MODIFY,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/free_block_bitmap_allocator_unit.sv
// Top level of the free block bitmap allocator: sequencer, map sweep and result register.
//
// One bit per disk block is kept in a RAM of ceil(MAX_BLOCKS/WORD_BITS) words, 1 meaning
// in use. After reset the block clears the map in a single pass over all words and stalls
// requests meanwhile. One transaction is worked on at a time. A find sweeps the map one
// word per cycle through the single RAM read port, up to limit, limit being the smaller of
// the block count and MAX_BLOCKS. A free or mark walks the same word counter up to the word
// holding the block and then does a read-modify-write. The next request is taken once a
// result is presented, and later while an earlier result still waits on a stalled response
// register. A finished result sits in the response register, so the next request is taken
// while it waits. The block count must be written through the csr port only while no
// transaction is in flight; the block itself does not enforce this.
module free_block_bitmap_allocator_unit
   import fbba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
   parameter int WORD_BITS  = WORD_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [INDEX_W-1:0]  req_block_index,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [INDEX_W-1:0]  rsp_block_number,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [COUNT_W-1:0]  csr_data
);

   localparam int MAP_DEPTH = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int SPAN_W    = $clog2(MAX_BLOCKS + WORD_BITS + 1);
   localparam int CNT_W     = (SPAN_W > COUNT_W) ? SPAN_W : COUNT_W;
   localparam int WB_W      = $clog2(WORD_BITS);

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);
   localparam logic [CNT_W-1:0]  CAPACITY  = CNT_W'(MAX_BLOCKS);
   localparam logic [CNT_W-1:0]  WORD_SPAN = CNT_W'(WORD_BITS);

   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]     base_ff, base_in;
   logic                 pend_ff, pend_in;
   logic [CNT_W-1:0]     pend_base_ff, pend_base_in;
   logic [FUNC_W-1:0]    func_ff, func_in;
   logic [INDEX_W-1:0]   idx_ff, idx_in;
   logic [WB_W-1:0]      bit_ff, bit_in;
   logic [INDEX_W-1:0]   res_number_ff, res_number_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_number_ff, rsp_number_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   count_ff;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic [ADDR_W-1:0]    ram_raddr;
   logic [WORD_BITS-1:0] ram_rdata;

   logic [CNT_W-1:0]     count_ext;
   logic [CNT_W-1:0]     limit;
   logic [CNT_W-1:0]     remain;
   logic [WORD_BITS-1:0] cand;
   logic                 found_any;
   logic [WB_W-1:0]      found_pos;
   logic [CNT_W-1:0]     found_block;
   logic [CNT_W-1:0]     idx_ext;
   logic [CNT_W-1:0]     idx_diff;
   logic                 issue;
   logic                 was_used;
   logic [WORD_BITS-1:0] bit_mask;

   fbba_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_DEPTH),
      .AW    (ADDR_W)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign count_ext = CNT_W'(count_ff);
   assign limit     = (count_ext > CAPACITY) ? CAPACITY : count_ext;
   assign remain    = limit - pend_base_ff;
   assign idx_ext   = CNT_W'(idx_ff);
   assign idx_diff  = idx_ext - base_ff;
   assign issue     = (base_ff < limit);
   assign was_used  = ram_rdata[bit_ff];
   assign bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_ff;

   // lowest free bit of the word just read, below the block limit
   always_comb begin
      found_any = 1'b0;
      found_pos = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         cand[i] = !ram_rdata[i] && (CNT_W'(i) < remain);
      end
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            found_any = 1'b1;
            found_pos = WB_W'(i);
         end
      end
   end

   assign found_block = pend_base_ff + CNT_W'(found_pos);

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      base_in       = base_ff;
      pend_in       = pend_ff;
      pend_base_in  = pend_base_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      bit_in        = bit_ff;
      res_number_in = res_number_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_number_in = rsp_number_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = ptr_ff;
      ram_wdata     = '0;
      ram_raddr     = ptr_ff;
      req_stall     = (state_ff != ST_IDLE);

      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ptr_in = ptr_ff + ADDR_W'(1);
            if (ptr_ff == LAST_ADDR) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               func_in       = req_func;
               idx_in        = req_block_index;
               ptr_in        = '0;
               base_in       = '0;
               pend_in       = 1'b0;
               res_number_in = '0;
               res_status_in = STATUS_OK;
               case (req_func)
                  FUNC_FIND: state_in = ST_FIND;
                  FUNC_FREE, FUNC_MARK: begin
                     if (CNT_W'(req_block_index) < CAPACITY) begin
                        state_in = ST_LOCATE;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_FIND: begin
            ram_raddr    = ptr_ff;
            pend_in      = issue;
            pend_base_in = base_ff;
            if (issue) begin
               ptr_in  = ptr_ff + ADDR_W'(1);
               base_in = base_ff + WORD_SPAN;
            end
            if (pend_ff && found_any) begin
               res_number_in = found_block[INDEX_W-1:0];
               state_in      = ST_DONE;
            end else if (!pend_ff && !issue) begin
               res_status_in = STATUS_NONE_FREE;
               state_in      = ST_DONE;
            end
         end
         ST_LOCATE: begin
            if (idx_ext >= base_ff && idx_diff < WORD_SPAN) begin
               ram_raddr = ptr_ff;
               bit_in    = idx_diff[WB_W-1:0];
               state_in  = ST_MODIFY;
            end else begin
               ptr_in  = ptr_ff + ADDR_W'(1);
               base_in = base_ff + WORD_SPAN;
            end
         end
         ST_MODIFY: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_ff;
            if (func_ff == FUNC_FREE) begin
               ram_wdata = ram_rdata & ~bit_mask;
               if (!was_used) begin
                  res_status_in = STATUS_WAS_FREE;
               end
            end else begin
               ram_wdata = ram_rdata | bit_mask;
               if (was_used) begin
                  res_status_in = STATUS_WAS_USED;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_number_in = res_number_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            count_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff       <= base_in;
      pend_base_ff  <= pend_base_in;
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      bit_ff        <= bit_in;
      res_number_ff <= res_number_in;
      res_status_ff <= res_status_in;
      rsp_number_ff <= rsp_number_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_block_number = rsp_number_ff;
   assign rsp_status       = rsp_status_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken but sequencer not busy");

   a_modify_after_locate: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MODIFY) |-> ($past(state_ff) == ST_LOCATE))
      else $error("map update without a located word");

   a_pending_below_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIND && pend_ff) |-> (pend_base_ff < limit))
      else $error("map word read past the block limit");

endmodule

FILE: rtl/fbba_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: tb/fbba_usage_map_checker.sv
// Predicts the allocator's results from the observed traffic and checks the result channel.
`timescale 1ns / 1ps
module fbba_usage_map_checker
   import fbba_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [INDEX_W-1:0]  req_block_index,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [INDEX_W-1:0]  rsp_block_number,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic [COUNT_W-1:0]  csr_data,
   output int                  error_count,
   output int                  outstanding
);

   typedef struct packed {
      logic [INDEX_W-1:0]  number;
      logic [STATUS_W-1:0] status;
   } alloc_result_type;

   alloc_result_type           expected_results[$];
   logic [MAX_BLOCKS_DEF-1:0]  used_map;
   logic [COUNT_W-1:0]         block_count;

   function automatic alloc_result_type predict_alloc(input logic [FUNC_W-1:0] f,
                                                      input logic [INDEX_W-1:0] idx);
      alloc_result_type r;
      int               lim;
      bit               found;
      r.number = '0;
      r.status = STATUS_OK;
      case (f)
         FUNC_FIND: begin
            lim = (block_count > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : int'(block_count);
            found = 1'b0;
            for (int b = 0; b < lim && !found; b++) begin
               if (!used_map[b]) begin
                  r.number = INDEX_W'(b);
                  found = 1'b1;
               end
            end
            if (!found) r.status = STATUS_NONE_FREE;
         end
         FUNC_FREE: begin
            if (!used_map[idx]) r.status = STATUS_WAS_FREE;
            used_map[idx] = 1'b0;
         end
         FUNC_MARK: begin
            if (used_map[idx]) r.status = STATUS_WAS_USED;
            used_map[idx] = 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      alloc_result_type got;
      alloc_result_type want;
      if (reset) begin
         used_map = '0;
         block_count = COUNT_RESET;
         expected_results.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) block_count = csr_data;
         if (req_valid && !req_stall)
            expected_results.push_back(predict_alloc(req_func, req_block_index));
         if (rsp_valid && !rsp_stall) begin
            got.number = rsp_block_number;
            got.status = rsp_status;
            if (expected_results.size() == 0) begin
               if (error_count < 10)
                  $display("unexpected result: number %0d status %0d", got.number, got.status);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (got.number !== want.number || got.status !== want.status) begin
                  if (error_count < 10)
                     $display("mismatch: expected number %0d status %0d, got number %0d status %0d",
                              want.number, want.status, got.number, got.status);
                  error_count++;
               end
            end
         end
      end
      outstanding = expected_results.size();
   end

endmodule

FILE: tb/free_block_bitmap_allocator_unit_tb.sv
// Stimulus and verdict for the free block bitmap allocator: directed cases, then random traffic.
`timescale 1ns / 1ps
module free_block_bitmap_allocator_unit_tb;
   import fbba_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 93;
   localparam int LONG_HOLD = 400;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func;
   logic [INDEX_W-1:0]  req_block_index;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [INDEX_W-1:0]  rsp_block_number;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_valid;
   logic                csr_ready;
   logic [COUNT_W-1:0]  csr_data;

   int error_count;
   int outstanding;
   int send_idle_pct;
   int stall_pct;
   int hold_cycles;
   int phase_count[PHASES];

   free_block_bitmap_allocator_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_block_number (rsp_block_number),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   fbba_usage_map_checker u_chk (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_block_index  (req_block_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_block_number (rsp_block_number),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .error_count      (error_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAIL free_block_bitmap_allocator_unit");
      $finish;
   end

   // result side backpressure, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall = 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic offer_request(input logic [FUNC_W-1:0] f, input logic [INDEX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = f;
      req_block_index = idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_results_drained();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_block_count(input logic [COUNT_W-1:0] value);
      csr_valid = 1'b1;
      csr_data = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic run_alloc_traffic(input int n_items, input int count_raw);
      int lim;
      int span;
      int low_span;
      int sent;
      int start;
      int run_len;
      int kind;
      lim = (count_raw > MAX_BLOCKS_DEF) ? MAX_BLOCKS_DEF : count_raw;
      span = lim + 16;
      if (span > MAX_BLOCKS_DEF) span = MAX_BLOCKS_DEF;
      low_span = (span < 160) ? span : 160;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(99);
         if (kind < 45) begin
            // fill a run of blocks, then look for the first hole
            start = ($urandom_range(3) == 0) ? $urandom_range(span - 1)
                                             : $urandom_range(low_span - 1);
            run_len = $urandom_range(1, 8);
            for (int k = 0; k < run_len && start + k < MAX_BLOCKS_DEF; k++) begin
               offer_request(FUNC_MARK, INDEX_W'(start + k));
               sent++;
            end
            offer_request(FUNC_FIND, INDEX_W'($urandom_range(MAX_BLOCKS_DEF - 1)));
            sent++;
         end else if (kind < 65) begin
            offer_request(FUNC_FREE, INDEX_W'($urandom_range(low_span - 1)));
            offer_request(FUNC_FIND, INDEX_W'($urandom_range(MAX_BLOCKS_DEF - 1)));
            sent += 2;
         end else if (kind < 85) begin
            offer_request(FUNC_W'($urandom_range(3)), INDEX_W'($urandom_range(low_span - 1)));
            sent++;
         end else begin
            offer_request(FUNC_W'($urandom_range(3)),
                          INDEX_W'($urandom_range(MAX_BLOCKS_DEF - 1)));
            sent++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_FIND;
      req_block_index = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      hold_cycles = 0;
      phase_count = '{0, 8191, 1, 64, 33, 4096, 100, 0, 200, 0};
      phase_count[7] = $urandom_range(8191);
      phase_count[9] = $urandom_range(300);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset block count
      offer_request(FUNC_FIND, '0);
      offer_request(FUNC_MARK, '0);
      offer_request(FUNC_MARK, '0);
      offer_request(FUNC_FIND, '1);
      offer_request(FUNC_FREE, '0);
      offer_request(FUNC_FREE, '0);
      offer_request(FUNC_MARK, 12'd1);
      offer_request(FUNC_FIND, '0);
      offer_request(FUNC_MARK, '1);
      offer_request(FUNC_MARK, '1);
      offer_request(FUNC_FREE, '1);
      offer_request(FUNC_FREE, '1);
      offer_request(FUNC_UNUSED, '1);
      offer_request(FUNC_UNUSED, '0);
      // zero count, count above capacity, count of one
      wait_results_drained();
      write_block_count('0);
      offer_request(FUNC_FIND, '0);
      offer_request(FUNC_MARK, 12'd5);
      wait_results_drained();
      write_block_count('1);
      offer_request(FUNC_FIND, '0);
      wait_results_drained();
      write_block_count(13'd1);
      offer_request(FUNC_MARK, '0);
      offer_request(FUNC_FIND, '0);
      offer_request(FUNC_FREE, 12'd1);
      offer_request(FUNC_FREE, '0);
      offer_request(FUNC_FIND, '0);

      for (int p = 0; p < PHASES; p++) begin
         wait_results_drained();
         write_block_count(COUNT_W'(phase_count[p]));
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
         endcase
         if (p == 3) hold_cycles = LONG_HOLD;
         run_alloc_traffic(PHASE_ITEMS, phase_count[p]);
      end

      wait_results_drained();
      repeat (200) @(negedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("PASS free_block_bitmap_allocator_unit");
      end else begin
         $display("FAIL free_block_bitmap_allocator_unit");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/fbba_pkg.sv
rtl/fbba_ram.sv
rtl/free_block_bitmap_allocator_unit.sv
tb/fbba_usage_map_checker.sv
tb/free_block_bitmap_allocator_unit_tb.sv
